@@ sv/psfg_pkg.sv @@
`timescale 1ns / 1ps
// Package for the playback sync frame generator: field widths, command and
// register codes, frame layout constants, the frame descriptor and the CRC-8 step.
// No dependencies.
package psfg_pkg;

	localparam int FUNC_W      = 3;
	localparam int TIME_W      = 32;
	localparam int IDX_W       = 8;
	localparam int PACK_W      = 16;
	localparam int BRI_W       = 8;
	localparam int BYTE_W      = 8;
	localparam int VER_W       = 2;
	localparam int INTERVAL_W  = 16;
	localparam int STAMP_W     = 16;
	localparam int BYTE_IDX_W  = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam int DEF_BURST_FRAMES = 3;
	localparam int DEF_QUEUE_DEPTH  = 2;

	localparam logic [BYTE_W-1:0]     RST_MAGIC    = 8'h00;
	localparam logic [VER_W-1:0]      RST_VERSION  = 2'd1;
	localparam logic [BYTE_W-1:0]     RST_POLY     = 8'h31;
	localparam logic [INTERVAL_W-1:0] RST_INTERVAL = 16'd100;

	localparam logic [BRI_W-1:0]      BRI_MAX      = 8'd100;
	localparam logic [BYTE_W-1:0]     FLAG_HARD    = 8'h02;
	localparam logic [BYTE_IDX_W-1:0] LAST_IDX     = 4'd13;

	typedef enum logic [FUNC_W-1:0] {
		FN_TICK   = 3'd0,
		FN_PLAY   = 3'd1,
		FN_STOP   = 3'd2,
		FN_SEEK   = 3'd3,
		FN_BRIGHT = 3'd4
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAGIC    = 2'd0,
		CFG_VERSION  = 2'd1,
		CFG_POLY     = 2'd2,
		CFG_INTERVAL = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_SEND = 1'b1
	} back_state_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  magic;
		logic [BYTE_W-1:0]  flags;
		logic [IDX_W-1:0]   index;
		logic [BYTE_W-1:0]  counter;
		logic [TIME_W-1:0]  progress;
		logic [STAMP_W-1:0] stamp;
		logic [BRI_W-1:0]   brightness;
		logic [PACK_W-1:0]  pack;
	} frame_desc_t;

	function automatic logic [BYTE_W-1:0] crc8_byte(
		input logic [BYTE_W-1:0] crc,
		input logic [BYTE_W-1:0] data,
		input logic [BYTE_W-1:0] poly
	);
		logic [BYTE_W-1:0] c;
		c = crc ^ data;
		for (int b = 0; b < BYTE_W; b++) begin
			if (c[BYTE_W-1]) begin
				c = {c[BYTE_W-2:0], 1'b0} ^ poly;
			end else begin
				c = {c[BYTE_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

@@ sv/psfg_if.sv @@
`timescale 1ns / 1ps
// Channel interfaces of the playback sync frame generator: command items,
// frame byte items and configuration writes. Depends on psfg_pkg.
interface psfg_cmd_if import psfg_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [FUNC_W-1:0]     func;
	logic [TIME_W-1:0]     now_ms;
	logic [IDX_W-1:0]      seq_index;
	logic [PACK_W-1:0]     pack_id;
	logic [BRI_W-1:0]      brightness;
	logic [TIME_W-1:0]     seek_progress_ms;

	modport source(output valid, func, now_ms, seq_index, pack_id, brightness,
		seek_progress_ms, input ready);
	modport sink(input valid, func, now_ms, seq_index, pack_id, brightness,
		seek_progress_ms, output ready);
endinterface

interface psfg_frm_if import psfg_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [BYTE_W-1:0]     frame_byte;
	logic [BYTE_IDX_W-1:0] byte_index;
	logic                  frame_end;
	logic                  run_last;

	modport source(output valid, frame_byte, byte_index, frame_end, run_last, input ready);
	modport sink(input valid, frame_byte, byte_index, frame_end, run_last, output ready);
endinterface

interface psfg_cfg_if import psfg_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ sv/psfg_front.sv @@
`timescale 1ns / 1ps
// Front part: accepts command and tick items, keeps the playback state and
// pushes one frame descriptor with its frame count. Depends on psfg_pkg, psfg_if.
module psfg_front import psfg_pkg::*; #(
	parameter int BURST_FRAMES = DEF_BURST_FRAMES,
	parameter int CNT_W        = $clog2(BURST_FRAMES + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	psfg_cmd_if.sink              cmd,
	input  logic [BYTE_W-1:0]     magic,
	input  logic [VER_W-1:0]      version,
	input  logic [INTERVAL_W-1:0] interval,
	input  logic                  q_full,
	output logic                  push,
	output frame_desc_t           push_desc,
	output logic [CNT_W-1:0]      push_cnt
);

	localparam logic [CNT_W-1:0] BURST_CNT = CNT_W'(BURST_FRAMES);
	localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

	logic               playing_q;
	logic [BYTE_W-1:0]  counter_q;
	logic [TIME_W-1:0]  start_q;
	logic [TIME_W-1:0]  last_send_q;
	logic [TIME_W-1:0]  progress_q;
	logic [IDX_W-1:0]   index_q;
	logic [PACK_W-1:0]  pack_q;
	logic [BRI_W-1:0]   bri_q;

	logic               playing_d;
	logic [BYTE_W-1:0]  counter_d;
	logic [TIME_W-1:0]  start_d;
	logic [TIME_W-1:0]  last_send_d;
	logic [TIME_W-1:0]  progress_d;
	logic [IDX_W-1:0]   index_d;
	logic [PACK_W-1:0]  pack_d;
	logic [BRI_W-1:0]   bri_d;
	logic [CNT_W-1:0]   frames;
	logic [TIME_W-1:0]  since_send;
	logic               due;
	logic               accept;

	assign cmd.ready  = !q_full;
	assign accept     = cmd.valid && cmd.ready;
	assign since_send = cmd.now_ms - last_send_q;
	assign due        = playing_q && (since_send >= {{(TIME_W-INTERVAL_W){1'b0}}, interval});

	always_comb begin
		playing_d   = playing_q;
		counter_d   = counter_q;
		start_d     = start_q;
		last_send_d = last_send_q;
		progress_d  = progress_q;
		index_d     = index_q;
		pack_d      = pack_q;
		bri_d       = bri_q;
		frames      = '0;
		case (cmd.func)
			FN_TICK: begin
				if (due) begin
					last_send_d = cmd.now_ms;
					progress_d  = cmd.now_ms - start_q;
					frames      = ONE_CNT;
				end
			end
			FN_PLAY: begin
				index_d     = cmd.seq_index;
				pack_d      = cmd.pack_id;
				bri_d       = cmd.brightness;
				playing_d   = 1'b1;
				start_d     = cmd.now_ms;
				progress_d  = '0;
				counter_d   = counter_q + 1'b1;
				last_send_d = cmd.now_ms;
				frames      = BURST_CNT;
			end
			FN_STOP: begin
				playing_d = 1'b0;
				frames    = BURST_CNT;
			end
			FN_SEEK: begin
				progress_d = cmd.seek_progress_ms;
				start_d    = cmd.now_ms - cmd.seek_progress_ms;
				counter_d  = counter_q + 1'b1;
				frames     = BURST_CNT;
			end
			FN_BRIGHT: begin
				bri_d  = (cmd.brightness > BRI_MAX) ? BRI_MAX : cmd.brightness;
				frames = BURST_CNT;
			end
			default: begin
				frames = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playing_q   <= 1'b0;
			counter_q   <= '0;
			start_q     <= '0;
			last_send_q <= '0;
			progress_q  <= '0;
			index_q     <= '0;
			pack_q      <= '0;
			bri_q       <= '0;
		end else if (accept) begin
			playing_q   <= playing_d;
			counter_q   <= counter_d;
			start_q     <= start_d;
			last_send_q <= last_send_d;
			progress_q  <= progress_d;
			index_q     <= index_d;
			pack_q      <= pack_d;
			bri_q       <= bri_d;
		end
	end

	assign push     = accept && (frames != '0);
	assign push_cnt = frames;

	always_comb begin
		push_desc.magic      = magic;
		push_desc.flags      = {version, {(BYTE_W-VER_W){1'b0}}} | FLAG_HARD
			| {{(BYTE_W-1){1'b0}}, playing_d};
		push_desc.index      = index_d;
		push_desc.counter    = counter_d;
		push_desc.progress   = progress_d;
		push_desc.stamp      = cmd.now_ms[STAMP_W-1:0];
		push_desc.brightness = bri_d;
		push_desc.pack       = pack_d;
	end

endmodule

@@ sv/psfg_fifo.sv @@
`timescale 1ns / 1ps
// Short queue of frame descriptors between the front and back parts.
// Depends on psfg_pkg.
module psfg_fifo import psfg_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == DEPTH_C);
	assign empty = (cnt_q == '0);
	assign rdata = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C) else $error("queue count beyond depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from empty queue");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");
	a_cnt_rise: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("queue count lost a push");
`endif

endmodule

@@ sv/psfg_back.sv @@
`timescale 1ns / 1ps
// Back part: takes frame descriptors from the queue and sends their bytes with
// a running CRC-8 through a registered output stage. Depends on psfg_pkg, psfg_if.
module psfg_back import psfg_pkg::*; #(
	parameter int BURST_FRAMES = DEF_BURST_FRAMES,
	parameter int CNT_W        = $clog2(BURST_FRAMES + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	psfg_frm_if.source        frm,
	input  logic [BYTE_W-1:0] poly,
	input  logic              q_empty,
	input  frame_desc_t       q_desc,
	input  logic [CNT_W-1:0]  q_cnt,
	output logic              pop
);

	localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

	back_state_t            state_q;
	back_state_t            state_d;
	frame_desc_t            desc_q;
	logic [CNT_W-1:0]       left_q;
	logic [BYTE_IDX_W-1:0]  idx_q;
	logic [BYTE_W-1:0]      crc_q;

	logic                   out_valid_q;
	logic [BYTE_W-1:0]      out_byte_q;
	logic [BYTE_IDX_W-1:0]  out_idx_q;
	logic                   out_end_q;
	logic                   out_last_q;

	logic                   advance;
	logic                   at_end;
	logic                   run_done;
	logic [BYTE_W-1:0]      cur_byte;
	logic [BYTE_W-1:0]      crc_in;

	assign at_end   = (idx_q == LAST_IDX);
	assign run_done = at_end && (left_q == ONE_CNT);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					state_d = BK_SEND;
				end
			end
			BK_SEND: begin
				if (advance && run_done) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_comb begin
		pop     = 1'b0;
		advance = 1'b0;
		case (state_q)
			BK_IDLE: begin
				pop = !q_empty;
			end
			BK_SEND: begin
				advance = !out_valid_q || frm.ready;
			end
			default: begin
				pop     = 1'b0;
				advance = 1'b0;
			end
		endcase
	end

	always_comb begin
		case (idx_q)
			4'd0:    cur_byte = desc_q.magic;
			4'd1:    cur_byte = desc_q.flags;
			4'd2:    cur_byte = desc_q.index;
			4'd3:    cur_byte = desc_q.counter;
			4'd4:    cur_byte = desc_q.progress[31:24];
			4'd5:    cur_byte = desc_q.progress[23:16];
			4'd6:    cur_byte = desc_q.progress[15:8];
			4'd7:    cur_byte = desc_q.progress[7:0];
			4'd8:    cur_byte = desc_q.stamp[15:8];
			4'd9:    cur_byte = desc_q.stamp[7:0];
			4'd10:   cur_byte = desc_q.brightness;
			4'd11:   cur_byte = desc_q.pack[15:8];
			4'd12:   cur_byte = desc_q.pack[7:0];
			4'd13:   cur_byte = crc_q;
			default: cur_byte = crc_q;
		endcase
	end

	assign crc_in = (idx_q == '0) ? '0 : crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			left_q  <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				left_q <= q_cnt;
				idx_q  <= '0;
			end else if (advance) begin
				if (at_end) begin
					idx_q  <= '0;
					left_q <= left_q - 1'b1;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			desc_q <= q_desc;
		end
		if (advance) begin
			crc_q <= crc8_byte(crc_in, cur_byte, poly);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (frm.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= cur_byte;
			out_idx_q  <= idx_q;
			out_end_q  <= at_end;
			out_last_q <= run_done;
		end
	end

	assign frm.valid      = out_valid_q;
	assign frm.frame_byte = out_byte_q;
	assign frm.byte_index = out_idx_q;
	assign frm.frame_end  = out_end_q;
	assign frm.run_last   = out_last_q;

`ifndef SYNTH
	a_end_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_end_q) |-> out_idx_q == LAST_IDX) else $error("frame end off position");
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |-> out_end_q) else $error("run end inside a frame");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && run_done) |=> state_q == BK_IDLE) else $error("send kept after last byte");
	a_send_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SEND) |-> left_q != '0) else $error("sending with no frames left");
`endif

endmodule

@@ sv/playback_sync_frame_generator.sv @@
`timescale 1ns / 1ps
// Playback sync frame generator top level: configuration registers, front part,
// descriptor queue and back part. Depends on psfg_pkg, psfg_if and all psfg_ modules.
// A command item is accepted while the descriptor queue (QUEUE_DEPTH entries, two by
// default) has room, so items can follow one another back to back; a play, stop,
// seek or brightness item yields 14 * BURST_FRAMES frame bytes, a due tick 14 bytes,
// and other items none. The byte sender sets throughput: one byte per cycle while the
// sink is ready, and it pauses to load each descriptor before sending its bytes.
// Configuration writes are taken every cycle. Magic and version are captured when
// an item is accepted, but the CRC polynomial is read as bytes are sent, so write
// registers only while no item is in flight.
module playback_sync_frame_generator import psfg_pkg::*; #(
	parameter int BURST_FRAMES = DEF_BURST_FRAMES,
	parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	psfg_cmd_if.sink     cmd,
	psfg_frm_if.source   frm,
	psfg_cfg_if.sink     cfg
);

	localparam int CNT_W = $clog2(BURST_FRAMES + 1);
	localparam int Q_W   = $bits(frame_desc_t) + CNT_W;

	logic [BYTE_W-1:0]     magic_q;
	logic [VER_W-1:0]      version_q;
	logic [BYTE_W-1:0]     poly_q;
	logic [INTERVAL_W-1:0] interval_q;

	logic                  push;
	frame_desc_t           push_desc;
	logic [CNT_W-1:0]      push_cnt;
	logic                  pop;
	logic [Q_W-1:0]        q_rdata;
	logic                  q_full;
	logic                  q_empty;
	frame_desc_t           q_desc;
	logic [CNT_W-1:0]      q_cnt;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q    <= RST_MAGIC;
			version_q  <= RST_VERSION;
			poly_q     <= RST_POLY;
			interval_q <= RST_INTERVAL;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_MAGIC:    magic_q    <= cfg.data[BYTE_W-1:0];
				CFG_VERSION:  version_q  <= cfg.data[VER_W-1:0];
				CFG_POLY:     poly_q     <= cfg.data[BYTE_W-1:0];
				CFG_INTERVAL: interval_q <= cfg.data[INTERVAL_W-1:0];
				default:      magic_q    <= magic_q;
			endcase
		end
	end

	psfg_front #(
		.BURST_FRAMES(BURST_FRAMES),
		.CNT_W       (CNT_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.magic    (magic_q),
		.version  (version_q),
		.interval (interval_q),
		.q_full   (q_full),
		.push     (push),
		.push_desc(push_desc),
		.push_cnt (push_cnt)
	);

	psfg_fifo #(
		.WIDTH(Q_W),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata ({push_cnt, push_desc}),
		.pop   (pop),
		.rdata (q_rdata),
		.full  (q_full),
		.empty (q_empty)
	);

	assign q_cnt  = q_rdata[Q_W-1 -: CNT_W];
	assign q_desc = frame_desc_t'(q_rdata[$bits(frame_desc_t)-1:0]);

	psfg_back #(
		.BURST_FRAMES(BURST_FRAMES),
		.CNT_W       (CNT_W)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.frm    (frm),
		.poly   (poly_q),
		.q_empty(q_empty),
		.q_desc (q_desc),
		.q_cnt  (q_cnt),
		.pop    (pop)
	);

endmodule
